/* sv/aawm_pkg.sv */
// shared constants and control structs for the activity window max block
// no dependencies
package aawm_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 17;
    localparam int SQ_W     = 32;
    localparam int ACC_W    = 34;
    localparam int REM_W    = 19;

    localparam int SQ_STEPS   = 4;
    localparam int SQRT_STEPS = ACC_W / 2;
    localparam int CNT_W      = 5;

    typedef struct packed {
        logic       capture;
        logic       prime;
        logic       sq_clear;
        logic       sq_step;
        logic [1:0] axis;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       ring_write;
        logic       scan_clear;
        logic       scan_step;
        logic       out_load;
        logic       out_win;
    } aawm_cmd_t;

    typedef struct packed {
        logic bad;
        logic present;
        logic fill_last;
        logic scan_done;
        logic out_free;
    } aawm_stat_t;

endpackage

/* sv/aawm_dp.sv */
// datapath: sample registers, shared squarer, bit-serial square root,
// level ring memory, window scan and output register; uses aawm_pkg
module aawm_dp import aawm_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  aawm_cmd_t                  cmd,
    output aawm_stat_t                 stat,
    input  logic signed [SAMPLE_W-1:0] s_accel_x,
    input  logic signed [SAMPLE_W-1:0] s_accel_y,
    input  logic signed [SAMPLE_W-1:0] s_accel_z,
    input  logic                       s_sample_bad,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [LEVEL_W-1:0]         m_window_max,
    output logic                       m_max_valid
);

    logic signed [SAMPLE_W-1:0] cur_reg [3];
    logic signed [SAMPLE_W-1:0] prev_reg [3];
    logic                       bad_reg;
    logic                       present_reg;

    logic [SQ_W-1:0]    prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [LEVEL_W-1:0] root_reg;

    logic [LEVEL_W-1:0] ring_mem [WINDOW_DEPTH];
    logic [LEVEL_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  scan_cnt_reg;
    logic [LEVEL_W-1:0] best_reg;

    logic                       m_valid_reg;
    logic [LEVEL_W-1:0]         m_max_reg;
    logic                       m_win_reg;

    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W-1:0]        mag;
    logic [REM_W+1:0]           rem_sh;
    logic [REM_W+1:0]           trial;
    logic                       fits;

    // delta of the selected axis
    always_comb begin
        unique case (cmd.axis)
            2'd0:    diff = {cur_reg[0][SAMPLE_W-1], cur_reg[0]}
                          - {prev_reg[0][SAMPLE_W-1], prev_reg[0]};
            2'd1:    diff = {cur_reg[1][SAMPLE_W-1], cur_reg[1]}
                          - {prev_reg[1][SAMPLE_W-1], prev_reg[1]};
            2'd2:    diff = {cur_reg[2][SAMPLE_W-1], cur_reg[2]}
                          - {prev_reg[2][SAMPLE_W-1], prev_reg[2]};
            default: diff = '0;
        endcase
        mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    end

    // one root bit per step
    always_comb begin
        rem_sh = {rem_reg, rad_reg[ACC_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            for (int i = 0; i < 3; i++) prev_reg[i] <= '0;
        end else begin
            if (cmd.prime || cmd.sqrt_init) begin
                present_reg <= 1'b1;
                for (int i = 0; i < 3; i++) prev_reg[i] <= cur_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_reg[0] <= s_accel_x;
            cur_reg[1] <= s_accel_y;
            cur_reg[2] <= s_accel_z;
            bad_reg    <= s_sample_bad;
        end
        if (cmd.sq_clear) begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end else if (cmd.sq_step) begin
            prod_reg <= SQ_W'(mag) * SQ_W'(mag);
            acc_reg  <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= acc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= {rad_reg[ACC_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[LEVEL_W-2:0], fits};
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.ring_write) begin
            ring_mem[slot_reg] <= root_reg;
        end
        rd_data_reg <= ring_mem[scan_cnt_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            fill_reg <= '0;
        end else if (cmd.ring_write) begin
            slot_reg <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            if (fill_reg != FILL_W'(WINDOW_DEPTH)) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // scan: read issued at count, compared in the next cycle from the registered read data
    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            scan_cnt_reg <= '0;
            best_reg     <= '0;
        end else if (cmd.scan_step) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
            if (scan_cnt_reg != '0 && rd_data_reg > best_reg) begin
                best_reg <= rd_data_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_max_reg <= cmd.out_win ? best_reg : '0;
            m_win_reg <= cmd.out_win;
        end
    end

    assign stat.bad       = bad_reg;
    assign stat.present   = present_reg;
    assign stat.fill_last = (fill_reg >= FILL_W'(WINDOW_DEPTH - 1));
    assign stat.scan_done = (scan_cnt_reg == FILL_W'(WINDOW_DEPTH));
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_window_max = m_max_reg;
    assign m_max_valid  = m_win_reg;

endmodule

/* sv/aawm_ctrl.sv */
// controller state machine sequencing one request through the datapath
// uses aawm_pkg
module aawm_ctrl import aawm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  aawm_stat_t stat,
    output aawm_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_SQ     = 3'd2;
    localparam logic [2:0] ST_RINIT  = 3'd3;
    localparam logic [2:0] ST_ROOT   = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_SCAN   = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             win_reg, win_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        win_next   = win_reg;
        cmd        = '0;
        cmd.axis   = cnt_reg[1:0];
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cnt_next = '0;
                win_next = 1'b0;
                priority if (stat.bad) begin
                    state_next = ST_FINISH;
                end else if (!stat.present) begin
                    cmd.prime  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.sq_clear = 1'b1;
                    state_next   = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_STEPS - 1)) begin
                    state_next = ST_RINIT;
                end
            end
            ST_RINIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.ring_write = 1'b1;
                cmd.scan_clear = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    win_next   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.out_win = win_reg;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            win_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            win_reg   <= win_next;
        end
    end

endmodule

/* sv/accel_activity_window_max.sv */
// top level of the accelerometer activity window maximum block
// instantiates aawm_ctrl and aawm_dp, uses aawm_pkg
//
// usage:
//   s_ channel carries one three-axis sample per request (valid/ready);
//   s_sample_bad marks a sample to be skipped, which leaves all state alone
//   m_ channel returns exactly one result per request: m_window_max and
//   m_max_valid, both zero unless the window is full and the sample good
//   the activity level is the floor square root of the squared distance
//   to the previous good sample; the first good sample only primes it
//   path from accept to result valid:
//     a bad or priming sample: decision, then output
//     while the window is still filling: squarer, root, ring write, output
//     with a full window: the window scan follows the ring write
//   the work is done by the shared squarer, the 17-step bit-serial square root
//   and the window scan over the ring memory read port, one entry a cycle
//   one request in flight; s_ready rises again once the result sits in the
//   output register, so the next request is taken while it waits
//   a stalled receiver holds the result; the block waits in its last
//   state until the output register is free
//   reset (aresetn low, synchronous) clears the previous sample, ring
//   position and fill count; the ring memory needs no clearing pass
module accel_activity_window_max import aawm_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_accel_x,
    input  logic signed [SAMPLE_W-1:0] s_accel_y,
    input  logic signed [SAMPLE_W-1:0] s_accel_z,
    input  logic                       s_sample_bad,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LEVEL_W-1:0]         m_window_max,
    output logic                       m_max_valid
);

    aawm_cmd_t  cmd;
    aawm_stat_t stat;

    // sequencer
    aawm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic, ring storage and output register
    aawm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_accel_x    (s_accel_x),
        .s_accel_y    (s_accel_y),
        .s_accel_z    (s_accel_z),
        .s_sample_bad (s_sample_bad),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_window_max (m_window_max),
        .m_max_valid  (m_max_valid)
    );

    // an invalid result always carries a zero maximum
    a_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_max_valid |-> m_window_max == '0)
        else $error("window max nonzero on invalid result");

    // only one request in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // output register never overwritten while a result is pending
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

endmodule
